@@ hdl/thm_pkg.sv @@
`default_nettype none
package thm_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;

   // segment length in unsigned fixed point, and its root pipeline
   localparam int LEN_W   = COORD_BITS + FRAC_BITS + 1;
   localparam int DSQ_W   = 2 * COORD_BITS + 1;
   localparam int SQ_W    = 2 * LEN_W;

   // heron product
   localparam int PER_W   = LEN_W + 2;
   localparam int FAC_W   = LEN_W + 1;
   localparam int P1_W    = PER_W + FAC_W;
   localparam int P2_W    = 2 * FAC_W;
   localparam int S1      = (P1_W + 1) / 2;
   localparam int S2      = (P2_W + 1) / 2;
   localparam int PROD_W  = P1_W + P2_W;
   localparam int ROOT_W  = (PROD_W + 1) / 2;
   localparam int RAD2_W  = 2 * ROOT_W;
   localparam int AREA_W  = 40;
   localparam int AREA_SH = FRAC_BITS + 2;

   localparam int LANES   = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [LEN_W-1:0] len_type;

   typedef struct packed {
      len_type            side_a;
      len_type            side_b;
      len_type            side_c;
      logic [PER_W-1:0]   perimeter_sum;
      logic               is_valid_triangle;
   } info_type;

   typedef struct packed {
      info_type           info;
      logic [AREA_W-1:0]  area_value;
   } rsp_type;

   // pipeline control shared by the stage modules
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_type;

endpackage
`default_nettype wire

@@ hdl/thm_sides.sv @@
`default_nettype none
module thm_sides (
   input  wire                   clock,
   input  wire                   reset,
   input  thm_pkg::pipe_type     pipe_i,
   input  thm_pkg::coord_type    coord [thm_pkg::LANES][4],
   output logic                  valid_o,
   output thm_pkg::len_type      len_o [thm_pkg::LANES]
);
   import thm_pkg::*;

   localparam int N = LEN_W;

   logic [COORD_BITS-1:0] ax_ff [LANES], ay_ff [LANES];
   logic [COORD_BITS-1:0] ax_in [LANES], ay_in [LANES];
   logic [2*COORD_BITS-1:0] sx_ff [LANES], sy_ff [LANES];
   logic v1_ff, v2_ff;

   logic [SQ_W-1:0] rad_ff [LANES][N+1];
   logic [N+1:0]    rem_ff [LANES][N+1];
   logic [N-1:0]    q_ff   [LANES][N+1];
   logic [SQ_W-1:0] rad_in [LANES][N+1];
   logic [N+1:0]    rem_in [LANES][N+1];
   logic [N-1:0]    q_in   [LANES][N+1];
   logic            v_ff   [N+1];

   // absolute coordinate differences
   always_comb begin
      logic signed [COORD_BITS:0] dx, dy;
      for (int l = 0; l < LANES; l++) begin
         dx = {coord[l][2][COORD_BITS-1], coord[l][2]} - {coord[l][0][COORD_BITS-1], coord[l][0]};
         dy = {coord[l][3][COORD_BITS-1], coord[l][3]} - {coord[l][1][COORD_BITS-1], coord[l][1]};
         ax_in[l] = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
         ay_in[l] = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      end
   end

   // squares and root radicand, one lane each
   for (genvar l = 0; l < LANES; l++) begin : g_front
      assign rad_in[l][0] = SQ_W'(DSQ_W'(sx_ff[l]) + DSQ_W'(sy_ff[l])) << (2 * FRAC_BITS);
      assign rem_in[l][0] = '0;
      assign q_in[l][0]   = '0;
      always_ff @(posedge clock) begin
         if (pipe_i.en) begin
            ax_ff[l] <= ax_in[l];
            ay_ff[l] <= ay_in[l];
            sx_ff[l] <= ax_ff[l] * ax_ff[l];
            sy_ff[l] <= ay_ff[l] * ay_ff[l];
            rad_ff[l][0] <= rad_in[l][0];
            rem_ff[l][0] <= rem_in[l][0];
            q_ff[l][0]   <= q_in[l][0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (pipe_i.en) begin
         v1_ff   <= pipe_i.valid;
         v2_ff   <= v1_ff;
         v_ff[0] <= v2_ff;
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < N; k++) begin : g_root
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [N+1:0] rt, tt;
         logic         ge;
         assign rt = {rem_ff[l][k][N-1:0], rad_ff[l][k][SQ_W-1 -: 2]};
         assign tt = {q_ff[l][k], 2'b01};
         assign ge = (rt >= tt);
         assign rem_in[l][k+1] = ge ? rt - tt : rt;
         assign q_in[l][k+1]   = {q_ff[l][k][N-2:0], ge};
         assign rad_in[l][k+1] = rad_ff[l][k] << 2;
         always_ff @(posedge clock) begin
            if (pipe_i.en) begin
               rem_ff[l][k+1] <= rem_in[l][k+1];
               q_ff[l][k+1]   <= q_in[l][k+1];
               rad_ff[l][k+1] <= rad_in[l][k+1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (pipe_i.en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   assign valid_o = v_ff[N];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         len_o[l] = q_ff[l][N];
      end
   end

endmodule
`default_nettype wire

@@ hdl/thm_area.sv @@
`default_nettype none
module thm_area (
   input  wire                   clock,
   input  wire                   reset,
   input  thm_pkg::pipe_type     pipe_i,
   input  thm_pkg::len_type      len_i [thm_pkg::LANES],
   output logic                  valid_o,
   output thm_pkg::rsp_type      rsp_o
);
   import thm_pkg::*;

   localparam int N = ROOT_W;

   info_type         info1_ff, info2_ff, info3_ff, info1_in;
   logic [FAC_W-1:0] f1_ff, f2_ff, f3_ff, f1_in, f2_in, f3_in;
   logic [P1_W-1:0]  p1_ff;
   logic [P2_W-1:0]  p2_ff;
   logic [2*S1-1:0]  ll_ff;
   logic [P1_W+S2-S1-1:0] hl_ff;
   logic [S1+P2_W-S2-1:0] lh_ff;
   logic [PROD_W-S1-S2-1:0] hh_ff;
   logic             v1_ff, v2_ff, v3_ff;

   logic [RAD2_W-1:0] rad_ff [N+1], rad_in [N+1];
   logic [N+1:0]      rem_ff [N+1], rem_in [N+1];
   logic [N-1:0]      q_ff   [N+1], q_in   [N+1];
   info_type          inf_ff [N+1];
   logic              v_ff   [N+1];

   // perimeter, triangle test and heron factors
   always_comb begin
      logic [PER_W-1:0] a, b, c, per;
      a = PER_W'(len_i[0]);
      b = PER_W'(len_i[1]);
      c = PER_W'(len_i[2]);
      per = a + b + c;
      info1_in.side_a = len_i[0];
      info1_in.side_b = len_i[1];
      info1_in.side_c = len_i[2];
      info1_in.perimeter_sum = per;
      info1_in.is_valid_triangle = (a < b + c) && (b < a + c) && (c < a + b);
      // zero factors force a zero area when the flag is clear
      f1_in = info1_in.is_valid_triangle ? FAC_W'(b + c - a) : '0;
      f2_in = info1_in.is_valid_triangle ? FAC_W'(a + c - b) : '0;
      f3_in = info1_in.is_valid_triangle ? FAC_W'(a + b - c) : '0;
   end

   always_comb begin
      rad_in[0] = RAD2_W'((PROD_W'(hh_ff) << (S1 + S2)) + (PROD_W'(hl_ff) << S1)
                          + (PROD_W'(lh_ff) << S2) + PROD_W'(ll_ff));
      rem_in[0] = '0;
      q_in[0]   = '0;
   end

   always_ff @(posedge clock) begin
      if (pipe_i.en) begin
         info1_ff <= info1_in;
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         f3_ff    <= f3_in;
         info2_ff <= info1_ff;
         p1_ff    <= P1_W'(info1_ff.perimeter_sum) * P1_W'(f1_ff);
         p2_ff    <= P2_W'(f2_ff) * P2_W'(f3_ff);
         info3_ff <= info2_ff;
         ll_ff    <= (2*S1)'(p1_ff[S1-1:0]) * (2*S1)'(p2_ff[S2-1:0]);
         hl_ff    <= (P1_W+S2-S1)'(p1_ff[P1_W-1:S1]) * (P1_W+S2-S1)'(p2_ff[S2-1:0]);
         lh_ff    <= (S1+P2_W-S2)'(p1_ff[S1-1:0]) * (S1+P2_W-S2)'(p2_ff[P2_W-1:S2]);
         hh_ff    <= (PROD_W-S1-S2)'(p1_ff[P1_W-1:S1]) * (PROD_W-S1-S2)'(p2_ff[P2_W-1:S2]);
         inf_ff[0] <= info3_ff;
         rad_ff[0] <= rad_in[0];
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (pipe_i.en) begin
         v1_ff   <= pipe_i.valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v_ff[0] <= v3_ff;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_root
      logic [N+1:0] rt, tt;
      logic         ge;
      assign rt = {rem_ff[k][N-1:0], rad_ff[k][RAD2_W-1 -: 2]};
      assign tt = {q_ff[k], 2'b01};
      assign ge = (rt >= tt);
      assign rem_in[k+1] = ge ? rt - tt : rt;
      assign q_in[k+1]   = {q_ff[k][N-2:0], ge};
      assign rad_in[k+1] = rad_ff[k] << 2;
      always_ff @(posedge clock) begin
         if (pipe_i.en) begin
            rem_ff[k+1] <= rem_in[k+1];
            q_ff[k+1]   <= q_in[k+1];
            rad_ff[k+1] <= rad_in[k+1];
            inf_ff[k+1] <= inf_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (pipe_i.en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   logic [N+AREA_W-1:0] area_wide;
   assign area_wide = (N + AREA_W)'(q_ff[N]) >> AREA_SH;

   assign valid_o = v_ff[N];
   always_comb begin
      rsp_o.info       = inf_ff[N];
      rsp_o.area_value = area_wide[AREA_W-1:0];
   end

endmodule
`default_nettype wire

@@ hdl/triangle_heron_measure_top.sv @@
`default_nettype none
// channel   dir   beat contents                         handshake
// req       in    three segments, two points each       req_valid / req_stall
// rsp       out   three sides, perimeter, flag, area    rsp_valid / rsp_stall
//
// one beat per cycle sustained while req_stall is low
// depth is set by the root pipelines: one result bit per stage, 25 for the
//    side lengths and 53 for the heron root, plus setup and multiply stages and the output register
// reset clears the stage valid bits and the output and skid valid bits only
// rsp_stall is taken by a skid register; the pipeline freezes only while it is full
module triangle_heron_measure_top (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  thm_pkg::coord_type          req_line1_start_x,
   input  thm_pkg::coord_type          req_line1_start_y,
   input  thm_pkg::coord_type          req_line1_end_x,
   input  thm_pkg::coord_type          req_line1_end_y,
   input  thm_pkg::coord_type          req_line2_start_x,
   input  thm_pkg::coord_type          req_line2_start_y,
   input  thm_pkg::coord_type          req_line2_end_x,
   input  thm_pkg::coord_type          req_line2_end_y,
   input  thm_pkg::coord_type          req_line3_start_x,
   input  thm_pkg::coord_type          req_line3_start_y,
   input  thm_pkg::coord_type          req_line3_end_x,
   input  thm_pkg::coord_type          req_line3_end_y,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output thm_pkg::len_type            rsp_side_a,
   output thm_pkg::len_type            rsp_side_b,
   output thm_pkg::len_type            rsp_side_c,
   output logic [thm_pkg::PER_W-1:0]   rsp_perimeter_sum,
   output logic                        rsp_is_valid_triangle,
   output logic [thm_pkg::AREA_W-1:0]  rsp_area_value
);
   import thm_pkg::*;

   coord_type coord [LANES][4];
   pipe_type  pipe_side, pipe_area;
   logic      side_v, area_v;
   len_type   side_len [LANES];
   rsp_type   area_rsp;

   rsp_type   out_ff, out_in, skid_ff, skid_in;
   logic      out_v_ff, out_v_in, skid_v_ff, skid_v_in;

   // whole pipeline moves together while the skid register is empty
   logic en;
   assign en = !skid_v_ff;
   assign req_stall = skid_v_ff;

   assign coord[0][0] = req_line1_start_x;
   assign coord[0][1] = req_line1_start_y;
   assign coord[0][2] = req_line1_end_x;
   assign coord[0][3] = req_line1_end_y;
   assign coord[1][0] = req_line2_start_x;
   assign coord[1][1] = req_line2_start_y;
   assign coord[1][2] = req_line2_end_x;
   assign coord[1][3] = req_line2_end_y;
   assign coord[2][0] = req_line3_start_x;
   assign coord[2][1] = req_line3_start_y;
   assign coord[2][2] = req_line3_end_x;
   assign coord[2][3] = req_line3_end_y;

   assign pipe_side.en    = en;
   assign pipe_side.valid = req_valid;
   assign pipe_area.en    = en;
   assign pipe_area.valid = side_v;

   // side lengths, three lanes in parallel
   thm_sides u_sides (
      .clock   (clock),
      .reset   (reset),
      .pipe_i  (pipe_side),
      .coord   (coord),
      .valid_o (side_v),
      .len_o   (side_len)
   );

   // perimeter, flag and heron area
   thm_area u_area (
      .clock   (clock),
      .reset   (reset),
      .pipe_i  (pipe_area),
      .len_i   (side_len),
      .valid_o (area_v),
      .rsp_o   (area_rsp)
   );

   // output register plus skid register
   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (area_v) begin
         if (!out_v_ff || !rsp_stall) begin
            out_in   = area_rsp;
            out_v_in = 1'b1;
         end else begin
            skid_in   = area_rsp;
            skid_v_in = 1'b1;
         end
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_side_a            = out_ff.info.side_a;
   assign rsp_side_b            = out_ff.info.side_b;
   assign rsp_side_c            = out_ff.info.side_c;
   assign rsp_perimeter_sum     = out_ff.info.perimeter_sum;
   assign rsp_is_valid_triangle = out_ff.info.is_valid_triangle;
   assign rsp_area_value        = out_ff.area_value;

endmodule
`default_nettype wire
